/* sv/alxd_pkg.sv */
// Shared types and constants of the length-prefixed XOR-checked frame receiver.
package alxd_pkg;

    // Field widths of one byte and of the parsed size.
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned SIZE_W = 10;

    // Byte positions inside a frame.
    localparam int unsigned POS_DIGITS_END = 3;
    localparam int unsigned POS_ID         = 3;
    localparam int unsigned POS_SUB_ID     = 4;
    localparam int unsigned POS_CTRL       = 5;
    localparam int unsigned POS_HELD       = 7;

    // ASCII decimal digit range.
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

    // Packed widths of the result channel.
    localparam int unsigned M_TDATA_W = 48;

    // Kind of a result transaction.
    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    // End-of-frame status fields.
    typedef struct packed {
        logic [BYTE_W-1:0] frame_id;
        logic [BYTE_W-1:0] frame_sub_id;
        logic [BYTE_W-1:0] frame_ctrl;
        logic              checksum_ok;
        logic              length_ok;
        logic              frame_valid;
        logic [SIZE_W-1:0] declared_length;
    } status_t;

    // Results caused by one input byte: an optional delayed data byte,
    // then an optional status.
    typedef struct packed {
        logic              data_vld;
        logic [BYTE_W-1:0] data_byte;
        logic              stat_vld;
        status_t           stat;
    } rec_t;

endpackage

/* sv/ascii_length_xor_deframer.sv */
// Top level of the length-prefixed frame receiver with XOR checksum.
//
// Input channel (s_): one frame byte per transaction in s_tdata, with
// s_tlast marking the checksum byte that ends the frame. A frame is three
// ASCII size digits, ID, sub-ID and control bytes, data bytes, checksum.
// Result channel (m_): m_tuser gives the kind (0 data, 1 status). Data bytes
// come out one input byte late; the checksum byte yields the status, after
// the last data byte if one is still held. m_tlast marks the final result
// caused by one input byte.
// Throughput is one byte per cycle while the buffer is not full. A result is
// stored when the byte that causes it is accepted. A two-record buffer parts
// the channels; s_tready drops only when it is full, which a checksum byte
// that also flushes a data byte can cause under a continuous stream.
// When m_tready is low, results wait in the buffer and input stops after two
// records are stored. Reset clears the frame state and empties the buffer.
module ascii_length_xor_deframer #(
    parameter int unsigned MAX_FRAME_BYTES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] payload_byte, [15:8] frame_id, [23:16] frame_sub_id,
    // [31:24] frame_ctrl, [32] checksum_ok, [33] length_ok,
    // [34] frame_valid, [44:35] declared_length, [47:45] zero
    output logic [alxd_pkg::M_TDATA_W-1:0] m_tdata,
    output logic        m_tuser,   // kind
    output logic        m_tlast    // last
);

    alxd_pkg::rec_t                rec;
    logic                          rec_vld;
    logic                          in_accept;
    alxd_pkg::kind_t               out_kind;
    logic [alxd_pkg::BYTE_W-1:0]   out_payload;
    alxd_pkg::status_t             out_stat;

    assign in_accept = s_tvalid && s_tready;

    alxd_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_parser (
        .clk      (aclk),
        .rst_n    (aresetn),
        .in_accept(in_accept),
        .in_byte  (s_tdata),
        .in_end   (s_tlast),
        .rec      (rec),
        .rec_vld  (rec_vld)
    );

    alxd_out_buf u_out_buf (
        .clk        (aclk),
        .rst_n      (aresetn),
        .wr_rec     (rec),
        .wr_en      (rec_vld),
        .wr_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (out_kind),
        .out_payload(out_payload),
        .out_stat   (out_stat),
        .out_last   (m_tlast)
    );

    // Pack the result fields, highest field first.
    assign m_tdata = {3'b000,
                      out_stat.declared_length,
                      out_stat.frame_valid,
                      out_stat.length_ok,
                      out_stat.checksum_ok,
                      out_stat.frame_ctrl,
                      out_stat.frame_sub_id,
                      out_stat.frame_id,
                      out_payload};
    assign m_tuser = out_kind;

endmodule

/* sv/alxd_parser.sv */
// Frame parser: size digits, header capture, running XOR and data delay.
module alxd_parser #(
    parameter int unsigned MAX_FRAME_BYTES = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_accept,
    input  logic [alxd_pkg::BYTE_W-1:0] in_byte,
    input  logic                        in_end,
    output alxd_pkg::rec_t              rec,
    output logic                        rec_vld
);

    localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned CMP_W = ((POS_W > alxd_pkg::SIZE_W) ? POS_W : alxd_pkg::SIZE_W) + 1;

    logic [POS_W-1:0]            pos_reg, pos_next;
    logic [alxd_pkg::SIZE_W-1:0] size_reg, size_next;
    logic                        stopped_reg, stopped_next;
    logic [alxd_pkg::BYTE_W-1:0] xor_reg, xor_next;
    logic [alxd_pkg::BYTE_W-1:0] held_reg, held_next;
    logic [alxd_pkg::BYTE_W-1:0] id_reg, id_next;
    logic [alxd_pkg::BYTE_W-1:0] sub_id_reg, sub_id_next;
    logic [alxd_pkg::BYTE_W-1:0] ctrl_reg, ctrl_next;

    logic                        has_held;
    logic                        is_digit;
    logic                        over;
    logic                        len_ok;
    logic                        ck_ok;
    logic [alxd_pkg::SIZE_W-1:0] size_x10;

    assign has_held = pos_reg >= POS_W'(alxd_pkg::POS_HELD);
    assign is_digit = (in_byte >= alxd_pkg::ASCII_ZERO) && (in_byte <= alxd_pkg::ASCII_NINE);
    assign over     = pos_reg >= POS_W'(MAX_FRAME_BYTES);
    assign size_x10 = {size_reg[alxd_pkg::SIZE_W-4:0], 3'b000}
                    + {size_reg[alxd_pkg::SIZE_W-2:0], 1'b0};

    // Frame length minus three equals the size when position equals size plus two.
    assign len_ok = !over && (pos_reg >= POS_W'(2))
                 && ((CMP_W'(pos_reg) - CMP_W'(2)) == CMP_W'(size_reg))
                 && (size_reg != '0);
    assign ck_ok  = in_byte == xor_reg;

    // Next state and the results of the accepted byte.
    always_comb begin
        pos_next     = pos_reg;
        size_next    = size_reg;
        stopped_next = stopped_reg;
        xor_next     = xor_reg;
        held_next    = held_reg;
        id_next      = id_reg;
        sub_id_next  = sub_id_reg;
        ctrl_next    = ctrl_reg;
        rec          = '0;
        rec.data_byte = held_reg;
        if (!in_end) begin
            if (pos_reg < POS_W'(alxd_pkg::POS_DIGITS_END)) begin
                if (!stopped_reg) begin
                    if (is_digit) begin
                        size_next = size_x10 + {{(alxd_pkg::SIZE_W-4){1'b0}}, in_byte[3:0]};
                    end else begin
                        stopped_next = 1'b1;
                    end
                end
            end else if (pos_reg == POS_W'(alxd_pkg::POS_ID)) begin
                id_next = in_byte;
            end else if (pos_reg == POS_W'(alxd_pkg::POS_SUB_ID)) begin
                sub_id_next = in_byte;
            end else if (pos_reg == POS_W'(alxd_pkg::POS_CTRL)) begin
                ctrl_next = in_byte;
            end else begin
                rec.data_vld = has_held;
                held_next    = in_byte;
            end
            xor_next = xor_reg ^ in_byte;
            if (!over) begin
                pos_next = pos_reg + POS_W'(1);
            end
        end else begin
            // Checksum byte: flush the held data byte, report, start over.
            rec.data_vld                 = has_held;
            rec.stat_vld                 = 1'b1;
            rec.stat.frame_id            = id_reg;
            rec.stat.frame_sub_id        = sub_id_reg;
            rec.stat.frame_ctrl          = ctrl_reg;
            rec.stat.checksum_ok         = ck_ok;
            rec.stat.length_ok           = len_ok;
            rec.stat.frame_valid         = ck_ok && len_ok;
            rec.stat.declared_length     = size_reg;
            pos_next     = '0;
            size_next    = '0;
            stopped_next = 1'b0;
            xor_next     = '0;
            held_next    = '0;
            id_next      = '0;
            sub_id_next  = '0;
            ctrl_next    = '0;
        end
    end

    assign rec_vld = in_accept && (rec.data_vld || rec.stat_vld);

    // Frame state registers.
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            pos_reg     <= '0;
            size_reg    <= '0;
            stopped_reg <= 1'b0;
            xor_reg     <= '0;
            held_reg    <= '0;
            id_reg      <= '0;
            sub_id_reg  <= '0;
            ctrl_reg    <= '0;
        end else if (in_accept) begin
            pos_reg     <= pos_next;
            size_reg    <= size_next;
            stopped_reg <= stopped_next;
            xor_reg     <= xor_next;
            held_reg    <= held_next;
            id_reg      <= id_next;
            sub_id_reg  <= sub_id_next;
            ctrl_reg    <= ctrl_next;
        end
    end

    // The byte counter never passes its bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_FRAME_BYTES))
        else $error("byte position passed its bound");

    // An accepted end byte always starts the next frame from position zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_end) |=> (pos_reg == '0) && !stopped_reg && (xor_reg == '0))
        else $error("frame state not cleared after end byte");

endmodule

/* sv/alxd_out_buf.sv */
// Two-record result buffer that serializes data and status transactions.
module alxd_out_buf (
    input  logic                        clk,
    input  logic                        rst_n,
    input  alxd_pkg::rec_t              wr_rec,
    input  logic                        wr_en,
    output logic                        wr_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output alxd_pkg::kind_t             out_kind,
    output logic [alxd_pkg::BYTE_W-1:0] out_payload,
    output alxd_pkg::status_t           out_stat,
    output logic                        out_last
);

    alxd_pkg::rec_t mem_reg [2];
    logic           head_reg, head_next;
    logic [1:0]     count_reg, count_next;
    logic           sent_reg, sent_next;

    alxd_pkg::rec_t head_rec;
    logic           emit_data;
    logic           out_fire;
    logic           pop;
    logic           tail;

    assign head_rec  = mem_reg[head_reg];
    assign tail      = head_reg ^ count_reg[0];
    assign wr_ready  = count_reg < 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign emit_data = head_rec.data_vld && !sent_reg;
    assign out_fire  = out_valid && out_ready;
    assign pop       = out_fire && !(emit_data && head_rec.stat_vld);

    // Present the data part of the head record first, then its status.
    always_comb begin
        if (emit_data) begin
            out_kind    = alxd_pkg::KIND_DATA;
            out_payload = head_rec.data_byte;
            out_stat    = '0;
            out_last    = !head_rec.stat_vld;
        end else begin
            out_kind    = alxd_pkg::KIND_STATUS;
            out_payload = '0;
            out_stat    = head_rec.stat;
            out_last    = 1'b1;
        end
    end

    // Pointer, fill count and the data-sent flag.
    always_comb begin
        head_next  = head_reg ^ pop;
        count_next = count_reg + {1'b0, wr_en} - {1'b0, pop};
        sent_next  = sent_reg;
        if (pop) begin
            sent_next = 1'b0;
        end else if (out_fire) begin
            sent_next = 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
            sent_reg  <= 1'b0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            sent_reg  <= sent_next;
        end
    end

    // Record storage.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[tail] <= wr_rec;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("result buffer count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (count_reg < 2'd2))
        else $error("write into a full result buffer");

    // A data transaction that is not last is followed by its status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && (out_kind == alxd_pkg::KIND_DATA) && !out_last)
        |=> (out_valid && (out_kind == alxd_pkg::KIND_STATUS)))
        else $error("status did not follow its data transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        sent_reg |-> (count_reg != 2'd0))
        else $error("data-sent flag set with empty buffer");

endmodule
